[design/assert_macros.svh]
// Assertion macros shared by the step order closure design.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/soc_pkg.sv]
// Package for the step order closure unit: sizes, request codes, word types,
// controller states and the command and status bundles. No dependencies.
package soc_pkg;

  localparam int MAX_STEPS = 64;
  localparam int ID_W      = 7;
  localparam int ROW_W     = MAX_STEPS;
  localparam int ROW_IDX_W = $clog2(MAX_STEPS);

  localparam logic [ID_W-1:0] INIT_ID = '0;
  localparam logic [ID_W-1:0] LAST_ID = ID_W'(MAX_STEPS);
  localparam logic [ID_W-1:0] GOAL_ID = ID_W'(MAX_STEPS + 1);

  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_ORDER = 2'd1;
  localparam logic [1:0] REQ_ADD   = 2'd2;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [ID_W-1:0] id_a;
    logic [ID_W-1:0] id_b;
  } soc_in_t;

  typedef struct packed {
    logic may_precede;
    logic may_follow;
    logic may_overlap;
    logic applied;
    logic status;
  } soc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_RD_A,
    ST_CHK,
    ST_LOOP,
    ST_DONE
  } soc_state_t;

  typedef struct packed {
    logic load;
    logic rd_b;
    logic rd_a;
    logic chk;
    logic step;
    logic emit;
  } soc_cmd_t;

  typedef struct packed {
    logic go_loop;
    logic loop_last;
  } soc_sts_t;

endpackage

[design/soc_ctrl.sv]
// Controller for the step order closure unit: sequences row reads, the
// closure sweep and the result strobe. Depends on soc_pkg.
module soc_ctrl
  import soc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  soc_sts_t sts,
  output soc_cmd_t cmd,
  output logic     busy
);

  soc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RD_B;
        end
      end
      ST_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = ST_RD_A;
      end
      ST_RD_A: begin
        cmd.rd_a  = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.go_loop ? ST_LOOP : ST_DONE;
      end
      ST_LOOP: begin
        cmd.step = 1'b1;
        if (sts.loop_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/soc_dpath.sv]
// Datapath for the step order closure unit: item registers, step count,
// precedence row memory with row valid bits, closure row update and result
// register. Depends on soc_pkg.
module soc_dpath
  import soc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  soc_in_t  in_word,
  input  soc_cmd_t cmd,
  output soc_sts_t sts,
  output logic     out_valid,
  output soc_out_t out_word
);

  // Item registers.
  logic [1:0]      req_r;
  logic [ID_W-1:0] a_r, b_r;
  logic [ID_W-1:0] n_r;

  // Row memory; a row that was never written reads as zero.
  logic [ROW_W-1:0]     mem_r [MAX_STEPS];
  logic [MAX_STEPS-1:0] vld_r;
  logic [ROW_W-1:0]     mem_q_r;
  logic                 rd_vld_r;
  logic [ROW_IDX_W-1:0] rd_addr;

  logic [ROW_W-1:0]     rowb_r;
  logic [ROW_IDX_W-1:0] k_r;
  logic                 pab_r, pba_r, applied_r, status_r;
  logic                 out_valid_r;
  soc_out_t             out_word_r, res;

  logic [ID_W-1:0]      a_dec, b_dec;
  logic [ROW_IDX_W-1:0] a_idx, b_idx;
  logic                 a_ord, b_ord, a_unk, b_unk, add_next;
  logic [ROW_W-1:0]     rd_row, b_ext, k_hot, row_upd, row_new;
  logic                 pab_now, pba_now, ord_ok, k_is_a, k_is_b, cond, we;
  logic                 a_spec, b_spec;

  assign a_dec = a_r - ID_W'(1);
  assign b_dec = b_r - ID_W'(1);
  assign a_idx = a_dec[ROW_IDX_W-1:0];
  assign b_idx = b_dec[ROW_IDX_W-1:0];

  assign a_ord = (a_r != INIT_ID) && (a_r <= LAST_ID);
  assign b_ord = (b_r != INIT_ID) && (b_r <= LAST_ID);
  assign a_unk = (a_r != INIT_ID) && (a_r != GOAL_ID) && (a_r > n_r);
  assign b_unk = (b_r != INIT_ID) && (b_r != GOAL_ID) && (b_r > n_r);
  assign add_next = (a_r == n_r + ID_W'(1)) && (a_r <= LAST_ID);

  assign rd_row  = rd_vld_r ? mem_q_r : '0;
  assign pab_now = a_ord && b_ord && (a_r != b_r) && rd_row[b_idx];
  assign pba_now = a_ord && b_ord && (a_r != b_r) && rowb_r[a_idx];
  assign ord_ok  = (req_r == REQ_ORDER) && !a_unk && !b_unk && a_ord && b_ord
                   && (a_r != b_r);

  // Row k gains b and every successor of b when k is a or precedes a.
  assign k_is_a  = (k_r == a_idx);
  assign k_is_b  = (k_r == b_idx);
  assign cond    = (k_is_a || rd_row[a_idx]) && !rd_row[b_idx];
  assign b_ext   = rowb_r | (ROW_W'(1) << b_idx);
  assign k_hot   = ROW_W'(1) << k_r;
  assign row_upd = rd_row | (b_ext & ~k_hot);
  assign row_new = cond ? row_upd : rd_row;
  assign we      = cmd.step && (row_new != rd_row);

  assign sts.go_loop   = ord_ok && !pab_now;
  assign sts.loop_last = ({1'b0, k_r} + ID_W'(1)) == n_r;

  always_comb begin
    priority if (cmd.rd_b) begin
      rd_addr = b_idx;
    end else if (cmd.rd_a) begin
      rd_addr = a_idx;
    end else if (cmd.chk) begin
      rd_addr = '0;
    end else begin
      rd_addr = k_r + ROW_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[k_r] <= row_new;
    end
    mem_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[k_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= ID_W'(1);
    end else if (cmd.chk && (req_r == REQ_ADD) && a_unk && add_next) begin
      n_r <= a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_word.req_type;
      a_r   <= in_word.id_a;
      b_r   <= in_word.id_b;
    end
    if (cmd.rd_a) begin
      rowb_r <= rd_row;
    end
    if (cmd.chk) begin
      k_r   <= '0;
      pab_r <= pab_now;
      pba_r <= pba_now;
      if (req_r == REQ_ADD) begin
        applied_r <= a_unk && add_next;
        status_r  <= a_unk && !add_next;
      end else begin
        applied_r <= 1'b0;
        status_r  <= a_unk || b_unk;
      end
    end
    if (cmd.step) begin
      k_r <= k_r + ROW_IDX_W'(1);
      if (we) begin
        applied_r <= 1'b1;
      end
      if (k_is_a) begin
        pab_r <= row_new[b_idx];
      end
      // Later rows must see the updated successor set of b.
      if (k_is_b) begin
        pba_r  <= row_new[a_idx];
        rowb_r <= row_new;
      end
    end
  end

  assign a_spec = (a_r == INIT_ID) || (a_r == GOAL_ID);
  assign b_spec = (b_r == INIT_ID) || (b_r == GOAL_ID);

  always_comb begin
    res = '0;
    priority if (a_r == b_r) begin
      res.may_precede = 1'b0;
      res.may_follow  = 1'b0;
    end else if ((a_r == INIT_ID) || (b_r == GOAL_ID)) begin
      res.may_precede = 1'b1;
      res.may_follow  = 1'b0;
    end else if ((a_r == GOAL_ID) || (b_r == INIT_ID)) begin
      res.may_precede = 1'b0;
      res.may_follow  = 1'b1;
    end else begin
      res.may_precede = !pba_r;
      res.may_follow  = !pab_r;
    end
    res.may_overlap = !a_spec && !b_spec && !pab_r && !pba_r;
    res.applied     = applied_r;
    res.status      = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[design/step_order_closure_unit.sv]
// Step order closure unit: a query or add-step word is accepted, reads the
// rows of b and a, is checked and then gives its result strobe; an ordering
// that runs the closure first sweeps the N rows, N the admitted step count,
// one matrix row a cycle through the single memory port. The next word is
// accepted while a result shows. Synchronous active-low reset empties the
// matrix via row valid bits and admits step 1; there is no clearing pass.
`include "assert_macros.svh"

module step_order_closure_unit
  import soc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  soc_in_t  in_word,
  output logic     out_valid,
  output soc_out_t out_word
);

  soc_cmd_t cmd;
  soc_sts_t sts;

  soc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  soc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  `SOC_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held")
  `SOC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `SOC_ASSERT_IMPL(a_overlap_both, out_valid && out_word.may_overlap,
                   out_word.may_precede == out_word.may_follow, "overlap with a one-sided order")
  `SOC_ASSERT_IMPL(a_applied_ok, out_valid && out_word.applied, !out_word.status,
                   "applied with error status")

endmodule
